// ===== sv/idmc_pkg.sv =====
// idmc_pkg: shared types and codes for the itemset direct-mapped cache
// no dependencies, compiled first
package idmc_pkg;

  localparam int CFG_W = 11;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

  localparam logic [10:0] BUCKET_COUNT_RST = 11'd1024;
  localparam logic [3:0] MAX_LENGTH_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_META,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

// ===== sv/idmc_if.sv =====
// idmc_req_if / idmc_rsp_if: valid/ready channels of the itemset cache
// no dependencies
interface idmc_req_if #(
  parameter int ITEM_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [ITEM_BITS-1:0] item;
  logic                 is_last;
  logic                 empty_set;

  modport source(output valid, item, is_last, empty_set, input ready);
  modport sink(input valid, item, is_last, empty_set, output ready);
endinterface

interface idmc_rsp_if #(
  parameter int SLOT_W = 10,
  parameter int OCC_W  = 11
);
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              created;
  logic              evicted;
  logic              is_root;
  logic              too_long;
  logic [OCC_W-1:0]  occupancy;

  modport source(output valid, slot, created, evicted, is_root, too_long, occupancy,
                 input ready);
  modport sink(input valid, slot, created, evicted, is_root, too_long, occupancy,
               output ready);
endinterface

// ===== sv/itemset_direct_mapped_cache.sv =====
// itemset_direct_mapped_cache: direct-mapped cache keyed by short item sequences
// uses idmc_pkg, idmc_if, idmc_ram, idmc_div
// a non-final item is taken while staying idle; root and overlong requests answer in the next cycle
// a lookup runs the serial remainder, then the bucket table read and the compare over the key
// ram port, and takes no further beat until it has answered and is back in idle
// after reset a clearing pass wipes every bucket of the table; no beats are accepted until it ends
module itemset_direct_mapped_cache
  import idmc_pkg::*;
#(
  parameter int BUCKETS = 1024,
  parameter int MAXLEN = 8,
  parameter int ITEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  idmc_req_if.sink             req,
  idmc_rsp_if.source           rsp
);

  // derived widths
  localparam int SLOT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int OCC_W = $clog2(BUCKETS + 1);
  localparam int DVS_W = $clog2(BUCKETS + 1);
  localparam int HW = ITEM_BITS + 1;                        // hash accumulator
  localparam int SC_W = $clog2(MAXLEN + 2);                 // staging count, saturates at MAXLEN+1
  localparam int IX_W = (MAXLEN > 1) ? $clog2(MAXLEN) : 1;  // staging index
  localparam int LEN_W = $clog2(MAXLEN + 1);                // stored length
  localparam int KDEPTH = BUCKETS * MAXLEN;
  localparam int KA_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int META_W = LEN_W + 1;                        // {valid, length}

  // configuration registers
  logic [10:0] bucket_count;
  logic [3:0]  max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count <= cfg_wdata[10:0];
        CFG_MAX_LENGTH:   max_length <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // control and staging state
  state_t state, state_next;

  logic [ITEM_BITS-1:0] stage [MAXLEN];
  logic [SC_W-1:0]      sc;          // staged item count
  logic [HW-1:0]        acc;         // running xor of item+2
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    clr_cnt;
  logic [IX_W-1:0]      chk_idx;     // key position under compare
  logic                 match;
  logic [OCC_W-1:0]     occ;

  // output register
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic              out_created;
  logic              out_evicted;
  logic              out_root;
  logic              out_long;
  logic [OCC_W-1:0]  out_occ;

  logic out_free;
  logic accept;

  assign out_free = !out_valid || rsp.ready;
  assign accept = req.valid && req.ready;

  // per-beat staging arithmetic
  logic [3:0]       folded;
  logic             stage_room;
  logic [SC_W-1:0]  sc_upd;
  logic [HW-1:0]    acc_upd;
  logic [HW-1:0]    hash_val;
  logic             seq_long;
  logic [DVS_W-1:0] divisor;
  logic [4:0]       pad_gap;

  always_comb begin
    folded = (max_length == 4'd0) ? 4'd1 : max_length;
    stage_room = 32'(sc) < MAXLEN;
    sc_upd = stage_room ? sc + 1'b1 : SC_W'(MAXLEN + 1);
    acc_upd = acc;
    if (stage_room && (32'(sc) < 32'(folded))) begin
      acc_upd = acc ^ ({1'b0, req.item} + HW'(2));
    end
    seq_long = 32'(sc_upd) > MAXLEN;
    // padding positions each fold in a 1, so only the parity of their count matters
    pad_gap = 5'(32'(folded) - 32'(sc_upd));
    hash_val = acc_upd;
    if ((32'(folded) > 32'(sc_upd)) && pad_gap[0]) begin
      hash_val = acc_upd ^ HW'(1);
    end
    // divisor clamped into 1..BUCKETS
    if (bucket_count == 11'd0) begin
      divisor = DVS_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      divisor = DVS_W'(BUCKETS);
    end else begin
      divisor = DVS_W'(bucket_count);
    end
  end

  // lookup kicks off on the last beat of a sequence that fits
  logic div_start;
  logic div_done;
  logic [SLOT_W-1:0] div_rem;

  assign div_start = accept && !req.empty_set && req.is_last && !seq_long;

  idmc_div #(
    .DEND_W(HW),
    .DVS_W (DVS_W),
    .REM_W (SLOT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hash_val),
    .divisor  (divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  // bucket table: valid bit and stored length per bucket
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;

  idmc_ram #(
    .WIDTH(META_W),
    .DEPTH(BUCKETS),
    .AW   (SLOT_W)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .raddr(slot),
    .rdata(meta_rdata)
  );

  // key store: MAXLEN item slots per bucket
  logic                 key_we;
  logic [KA_W-1:0]      key_waddr;
  logic [KA_W-1:0]      key_raddr;
  logic [ITEM_BITS-1:0] key_rdata;
  logic [ITEM_BITS-1:0] stage_cur;

  assign stage_cur = stage[chk_idx];

  idmc_ram #(
    .WIDTH(ITEM_BITS),
    .DEPTH(KDEPTH),
    .AW   (KA_W)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(stage_cur),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  // compare pipeline: read of position i+1 goes out while position i is checked
  // and rewritten; the staged items equal the stored ones on a hit, so the
  // rewrite is always safe and saves a second pass on a miss
  logic cmp_last;
  logic key_eq;
  logic meta_valid;
  logic len_eq;
  logic hit;
  logic fin_fire;

  always_comb begin
    key_waddr = KA_W'(32'(slot) * MAXLEN + 32'(chk_idx));
    if (state == ST_META) begin
      key_raddr = KA_W'(32'(slot) * MAXLEN);
    end else begin
      key_raddr = KA_W'(32'(slot) * MAXLEN + 32'(chk_idx) + 1);
    end
    cmp_last = (32'(chk_idx) + 1) == 32'(sc);
    key_eq = key_rdata == stage_cur;
    meta_valid = meta_rdata[META_W-1];
    len_eq = meta_rdata[LEN_W-1:0] == LEN_W'(sc);
    hit = meta_valid && len_eq && match;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram strobes
  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    key_we = 1'b0;
    meta_we = 1'b0;
    meta_waddr = slot;
    meta_wdata = {1'b1, LEN_W'(sc)};
    fin_fire = 1'b0;
    case (state)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_waddr = clr_cnt;
        meta_wdata = '0;
        if (32'(clr_cnt) == BUCKETS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = out_free;
        // same condition as div_start, taken from valid so ready is not fed back
        if (req.valid && out_free && !req.empty_set && req.is_last && !seq_long) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_META;
        end
      end
      ST_META: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        key_we = 1'b1;
        if (cmp_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // table update and result go together once the output register is free
        if (out_free) begin
          fin_fire = 1'b1;
          meta_we = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0;
      acc <= '0;
      clr_cnt <= '0;
      chk_idx <= '0;
      match <= 1'b0;
      occ <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end

      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        if (req.empty_set) begin
          // root request drops any partial sequence
          sc <= '0;
          acc <= '0;
          out_valid <= 1'b1;
        end else if (req.is_last) begin
          acc <= '0;
          if (seq_long) begin
            sc <= '0;
            out_valid <= 1'b1;
          end else begin
            sc <= sc_upd;  // kept as the sequence length until the lookup ends
          end
        end else begin
          sc <= sc_upd;
          acc <= acc_upd;
        end
      end

      if (state == ST_META) begin
        chk_idx <= '0;
        match <= 1'b1;
      end else if (state == ST_CMP) begin
        match <= match && key_eq;
        chk_idx <= chk_idx + 1'b1;
      end

      if (fin_fire) begin
        out_valid <= 1'b1;
        sc <= '0;
        if (!meta_valid) begin
          occ <= occ + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && stage_room && !req.empty_set) begin
      stage[sc[IX_W-1:0]] <= req.item;
    end

    if (state == ST_DIV && div_done) begin
      slot <= div_rem;
    end

    if (accept && (req.empty_set || (req.is_last && seq_long))) begin
      out_slot <= '0;
      out_created <= req.empty_set;
      out_evicted <= 1'b0;
      out_root <= req.empty_set;
      out_long <= !req.empty_set;
      out_occ <= occ;
    end else if (fin_fire) begin
      out_slot <= slot;
      out_created <= !hit;
      out_evicted <= meta_valid && !hit;
      out_root <= 1'b0;
      out_long <= 1'b0;
      out_occ <= meta_valid ? occ : occ + 1'b1;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.slot = out_slot;
  assign rsp.created = out_created;
  assign rsp.evicted = out_evicted;
  assign rsp.is_root = out_root;
  assign rsp.too_long = out_long;
  assign rsp.occupancy = out_occ;

endmodule

// ===== sv/idmc_ram.sv =====
// idmc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module idmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/idmc_div.sv =====
// idmc_div: bit-serial restoring remainder unit, one dividend bit per cycle
// no dependencies
module idmc_div #(
  parameter int DEND_W = 17,
  parameter int DVS_W  = 11,
  parameter int REM_W  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [REM_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DEND_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DEND_W-1:0] shreg;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic [DVS_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, shreg[DEND_W-1]};
    diff = trial - {1'b0, dvs};
    rem_next = (trial >= {1'b0, dvs}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      shreg <= {shreg[DEND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // remainder is below the divisor, which the cache clamps to at most BUCKETS
  assign remainder = rem[REM_W-1:0];

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for itemset_direct_mapped_cache, with its own cache predictor
// depends on idmc_pkg, the idmc_req_if / idmc_rsp_if interfaces and itemset_direct_mapped_cache
module tb
  import idmc_pkg::*;
();

  localparam int BUCKETS = 1024;
  localparam int MAXLEN = 8;
  localparam int ITEM_BITS = 16;
  localparam int POOL_SIZE = 16;
  // settle time that covers a beat still in work
  localparam int SETTLE_CYCLES = 64;
  // reset clearing pass plus the longest lookup under heavy stalls, several times over
  localparam int STALL_LIMIT = 6000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0] item;
    logic                 is_last;
    logic                 empty_set;
  } req_beat_t;

  typedef struct packed {
    logic [9:0]  slot;
    logic        created;
    logic        evicted;
    logic        is_root;
    logic        too_long;
    logic [10:0] occupancy;
  } lookup_result_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  idmc_req_if #(.ITEM_BITS(ITEM_BITS)) req ();
  idmc_rsp_if rsp ();

  itemset_direct_mapped_cache #(
    .BUCKETS(BUCKETS),
    .MAXLEN(MAXLEN),
    .ITEM_BITS(ITEM_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req(req),
    .rsp(rsp)
  );

  // request beats waiting for the driver, and lookup results the block still owes us
  req_beat_t req_beats[$];
  lookup_result_t results_due[$];
  req_beat_t beat_on_bus;
  idle_mode_t idle_mode;

  // shadow of the cache contents
  logic [ITEM_BITS-1:0] stored_keys[BUCKETS*MAXLEN];
  int stored_len[BUCKETS];
  bit bucket_full[BUCKETS];
  logic [10:0] fill_count;
  // shadow of the sequence being staged
  logic [ITEM_BITS-1:0] seq_items[MAXLEN];
  int seq_count;
  logic [ITEM_BITS:0] seq_hash;
  // shadow of the registers
  logic [10:0] shadow_bucket_count;
  logic [3:0] shadow_max_length;

  // sequences kept around so that later requests can hit them
  logic [ITEM_BITS-1:0] pool_items[POOL_SIZE*MAXLEN];
  int pool_len[POOL_SIZE];
  int pool_fill;

  int pushed_beats;
  int accepted_beats;
  int results_checked;
  int errors;
  int stall_cycles;
  int settings_used;
  int hit_count, fill_new_count, evict_count, root_count, overlong_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: folds one accepted request beat into the shadow state and queues
  // the lookup result it causes, if any
  // ---------------------------------------------------------------------------
  function automatic void cache_lookup(input req_beat_t beat);
    int folded;
    int divisor;
    int unsigned key_hash;
    int slot;
    int i;
    bit hit;
    lookup_result_t res;
    res = '0;
    if (beat.empty_set) begin
      // root request: any staged prefix is dropped, item and is_last don't matter
      seq_count = 0;
      seq_hash = '0;
      res.created = 1'b1;
      res.is_root = 1'b1;
      res.occupancy = fill_count;
      root_count++;
      results_due.push_back(res);
      return;
    end
    // max_length is sampled per beat; zero still folds position 0
    folded = (shadow_max_length == 0) ? 1 : int'(shadow_max_length);
    if (seq_count < MAXLEN) begin
      seq_items[seq_count] = beat.item;
      if (seq_count < folded) seq_hash ^= {1'b0, beat.item} + (ITEM_BITS+1)'(2);
      seq_count++;
    end else begin
      // overlong: count saturates one past MAXLEN, extra items dropped
      seq_count = MAXLEN + 1;
    end
    if (!beat.is_last) return;
    if (seq_count > MAXLEN) begin
      seq_count = 0;
      seq_hash = '0;
      res.too_long = 1'b1;
      res.occupancy = fill_count;
      overlong_count++;
      results_due.push_back(res);
      return;
    end
    // every unfilled folded position contributes 1, so only the parity matters
    key_hash = seq_hash;
    if (folded > seq_count && ((folded - seq_count) % 2) == 1) key_hash ^= 1;
    // divisor clamps: zero acts as one, anything past the table acts as the table size
    divisor = (shadow_bucket_count == 0) ? 1 : int'(shadow_bucket_count);
    if (divisor > BUCKETS) divisor = BUCKETS;
    slot = int'(key_hash % divisor);
    hit = bucket_full[slot] && (stored_len[slot] == seq_count);
    if (hit) begin
      for (i = 0; i < seq_count; i++)
        if (stored_keys[slot*MAXLEN+i] != seq_items[i]) hit = 1'b0;
    end
    res.slot = 10'(slot);
    if (hit) begin
      hit_count++;
    end else begin
      res.created = 1'b1;
      if (bucket_full[slot]) begin
        res.evicted = 1'b1;
        evict_count++;
      end else begin
        fill_count++;
        fill_new_count++;
      end
      bucket_full[slot] = 1'b1;
      stored_len[slot] = seq_count;
      for (i = 0; i < seq_count; i++) stored_keys[slot*MAXLEN+i] = seq_items[i];
    end
    seq_count = 0;
    seq_hash = '0;
    res.occupancy = fill_count;
    results_due.push_back(res);
  endfunction

  function automatic bit sender_pause();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 67;
      IDLE_BOTH:   return $urandom_range(99) < 11;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 67;
      IDLE_BOTH:     return $urandom_range(99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: predicts on each accepted beat, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.item <= '0;
      req.is_last <= 1'b0;
      req.empty_set <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        cache_lookup(beat_on_bus);
        accepted_beats++;
      end
      if (!req.valid || req.ready) begin
        if (req_beats.size() > 0 && !sender_pause()) begin
          beat_on_bus = req_beats.pop_front();
          req.valid <= 1'b1;
          req.item <= beat_on_bus.item;
          req.is_last <= beat_on_bus.is_last;
          req.empty_set <= beat_on_bus.empty_set;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input lookup_result_t want,
                                 input lookup_result_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected slot %0d created %0b evicted %0b root %0b too_long %0b occ %0d",
               want.slot, want.created, want.evicted, want.is_root, want.too_long,
               want.occupancy);
      $display("  actual   slot %0d created %0b evicted %0b root %0b too_long %0b occ %0d",
               got.slot, got.created, got.evicted, got.is_root, got.too_long, got.occupancy);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result monitor: compares each accepted result beat with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin : check_beat
        lookup_result_t got;
        lookup_result_t want;
        got.slot = rsp.slot;
        got.created = rsp.created;
        got.evicted = rsp.evicted;
        got.is_root = rsp.is_root;
        got.too_long = rsp.too_long;
        got.occupancy = rsp.occupancy;
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, got);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (got !== want) report_mismatch("result beat mismatch", want, got);
        end
      end
      rsp.ready <= !receiver_stall();
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, results_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(input logic [ITEM_BITS-1:0] item, input logic is_last,
                           input logic empty_set);
    req_beat_t b;
    b.item = item;
    b.is_last = is_last;
    b.empty_set = empty_set;
    req_beats.push_back(b);
    pushed_beats++;
  endtask

  // small values crowd the hash so buckets collide; extremes and full-width values too
  function automatic logic [ITEM_BITS-1:0] pick_item();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return ITEM_BITS'($urandom_range(15));
      default: return ITEM_BITS'($urandom);
    endcase
  endfunction

  // the caller must only change registers with no request in flight; this task does not enforce it
  task automatic apply_config(input int bkt, input int ml);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= CFG_BUCKET_COUNT;
    cfg_wdata <= CFG_W'(bkt);
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_wdata <= CFG_W'(ml);
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_bucket_count = 11'(bkt);
    shadow_max_length = 4'(ml);
    settings_used++;
  endtask

  // every pushed beat accepted and every result back, then let a staged beat finish
  task automatic wait_drained();
    while (accepted_beats != pushed_beats || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed sequences, with reuse for hits, plus roots, overlong and aborted ones
  task automatic random_phase(input int n_beats, input bit leave_open);
    int done;
    int len;
    int p;
    int i;
    logic [ITEM_BITS-1:0] it;
    done = 0;
    while (done < n_beats) begin
      case ($urandom_range(99)) inside
        [0:7]: begin
          // root request with stray item bits and either is_last
          push_beat(pick_item(), 1'($urandom_range(1)), 1'b1);
          done += 1;
        end
        [8:13]: begin
          len = $urandom_range(MAXLEN + 4, MAXLEN + 1);
          for (i = 0; i < len; i++) push_beat(pick_item(), i == len - 1, 1'b0);
          done += len;
        end
        [14:19]: begin
          // partial sequence abandoned by a root request
          len = $urandom_range(3, 1);
          for (i = 0; i < len; i++) push_beat(pick_item(), 1'b0, 1'b0);
          push_beat(pick_item(), 1'($urandom_range(1)), 1'b1);
          done += len + 1;
        end
        [20:54]: begin
          if (pool_fill > 0) begin
            p = $urandom_range(pool_fill - 1);
            for (i = 0; i < pool_len[p]; i++)
              push_beat(pool_items[p*MAXLEN+i], i == pool_len[p] - 1, 1'b0);
            done += pool_len[p];
          end
        end
        default: begin
          // fresh sequence, mostly short, remembered for later hits
          len = ($urandom_range(99) < 70) ? $urandom_range(3, 1) : $urandom_range(MAXLEN, 1);
          if (pool_fill < POOL_SIZE) begin
            p = pool_fill;
            pool_fill++;
          end else begin
            p = $urandom_range(POOL_SIZE - 1);
          end
          pool_len[p] = len;
          for (i = 0; i < len; i++) begin
            it = pick_item();
            pool_items[p*MAXLEN+i] = it;
            push_beat(it, i == len - 1, 1'b0);
          end
          done += len;
        end
      endcase
    end
    // a dangling prefix carries over the next register change
    if (leave_open) push_beat(pick_item(), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [ITEM_BITS-1:0] edge_items[MAXLEN];
    int ph;
    int bkt;
    int ml;
    idle_mode_t mode;
    // everything known from time zero
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.item = '0;
    req.is_last = 1'b0;
    req.empty_set = 1'b0;
    rsp.ready = 1'b0;
    idle_mode = IDLE_NONE;
    pushed_beats = 0;
    accepted_beats = 0;
    results_checked = 0;
    errors = 0;
    stall_cycles = 0;
    settings_used = 0;
    hit_count = 0;
    fill_new_count = 0;
    evict_count = 0;
    root_count = 0;
    overlong_count = 0;
    pool_fill = 0;
    fill_count = '0;
    seq_count = 0;
    seq_hash = '0;
    shadow_bucket_count = BUCKET_COUNT_RST;
    shadow_max_length = MAX_LENGTH_RST;
    for (int b = 0; b < BUCKETS; b++) bucket_full[b] = 1'b0;
    edge_items = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001,
                   16'h8000, 16'h7FFF, 16'hFFFE, 16'h0002};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    apply_config(1024, 8);

    // directed part, reset-like settings, no idling
    push_beat(16'h5A5A, 1'b1, 1'b1);              // root with junk item
    push_beat(16'h0000, 1'b1, 1'b0);              // fills bucket 3
    push_beat(16'h0000, 1'b1, 1'b0);              // same sequence: hit
    push_beat(16'h0002, 1'b0, 1'b0);              // {2,5} also lands in bucket 3
    push_beat(16'h0005, 1'b1, 1'b0);              //   and evicts {0}
    push_beat(16'h0001, 1'b0, 1'b0);              // prefix thrown away by
    push_beat(16'hA5A5, 1'b0, 1'b1);              //   a root without is_last
    for (int i = 0; i < MAXLEN; i++)              // full-length sequence of extremes,
      push_beat(edge_items[i], i == MAXLEN - 1, 1'b0);  // carry out of item + 2
    for (int i = 0; i <= MAXLEN; i++)             // one item too many
      push_beat(edge_items[i % MAXLEN] ^ 16'h00F0, i == MAXLEN, 1'b0);
    push_beat(16'h0007, 1'b0, 1'b0);              // left open across the register change
    wait_drained();

    // random phases walking through the register extremes and idle patterns
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin bkt = 2047; ml = 15; mode = IDLE_NONE; end
        1: begin bkt = 0; ml = 0; mode = IDLE_SENDER; end
        2: begin bkt = 1; ml = 1; mode = IDLE_RECEIVER; end
        3: begin bkt = 7; ml = 3; mode = IDLE_BOTH; end
        4: begin bkt = 1024; ml = 8; mode = IDLE_SENDER; end
        5: begin
          bkt = $urandom_range(64, 2);
          ml = $urandom_range(MAXLEN, 1);
          mode = IDLE_RECEIVER;
        end
        6: begin bkt = 1025; ml = 9; mode = IDLE_BOTH; end
        default: begin bkt = 16; ml = 4; mode = IDLE_NONE; end
      endcase
      apply_config(bkt, ml);
      idle_mode = mode;
      random_phase(78, 1'($urandom_range(1)));
      wait_drained();
    end

    $display("ran %0d request beats and checked %0d lookup results over %0d register settings",
             accepted_beats, results_checked, settings_used);
    $display("hits %0d, new fills %0d, evictions %0d, root %0d, overlong %0d, mismatches %0d",
             hit_count, fill_new_count, evict_count, root_count, overlong_count, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
